[hdl/wsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack interpreter package
// Shared types, opcodes and a helper function for the bytecode interpreter.
// ----------------------------------------------------------------------------
package wsi_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned LOCAL_SLOTS_DEF = 64;

  localparam logic [7:0] OP_UNREACHABLE = 8'h00;
  localparam logic [7:0] OP_RETURN      = 8'h0F;
  localparam logic [7:0] OP_CALL        = 8'h10;
  localparam logic [7:0] OP_DROP        = 8'h1A;
  localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
  localparam logic [7:0] OP_LOCAL_SET   = 8'h21;
  localparam logic [7:0] OP_I32_CONST   = 8'h41;
  localparam logic [7:0] OP_I64_CONST   = 8'h42;
  localparam logic [7:0] OP_I32_EQ      = 8'h46;
  localparam logic [7:0] OP_I32_LT_S    = 8'h48;
  localparam logic [7:0] OP_I32_ADD     = 8'h6A;
  localparam logic [7:0] OP_I32_SUB     = 8'h6B;
  localparam logic [7:0] OP_I32_MUL     = 8'h6C;
  localparam logic [7:0] OP_I32_AND     = 8'h71;
  localparam logic [7:0] OP_I32_OR      = 8'h72;

  typedef enum logic [1:0] {
    ST_EXEC   = 2'd0,
    ST_RETURN = 2'd1,
    ST_TRAP   = 2'd2,
    ST_END    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DECLS,
    PH_GROUP_N,
    PH_GROUP_T,
    PH_OP,
    PH_IMM_U,
    PH_IMM_S
  } phase_e;

  typedef enum logic [2:0] {
    EX_NONE,
    EX_PUSH,
    EX_PUSH_LOCAL,
    EX_DROP,
    EX_SET_LOCAL,
    EX_BINOP
  } exec_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_cmd_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       body_start;
    logic       body_last;
  } wsi_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  opcode;
    logic [8:0]  depth;
    logic [63:0] top_value;
  } wsi_out_t;

  // Decoded work for the execute stage.
  typedef struct packed {
    logic        clear;
    logic        emit;
    status_e     status;
    logic [7:0]  opcode;
    exec_e       kind;
    logic [63:0] imm;
  } wsi_exec_t;

  function automatic logic [31:0] wsi_binop(input logic [7:0] op, input logic [31:0] a,
                                            input logic [31:0] b);
    logic [31:0] r;
    case (op)
      OP_I32_ADD: r = a + b;
      OP_I32_SUB: r = a - b;
      OP_I32_MUL: r = a * b;
      OP_I32_AND: r = a & b;
      OP_I32_OR:  r = a | b;
      OP_I32_EQ:  r = {31'd0, a == b};
      default:    r = {31'd0, $signed(a) < $signed(b)};
    endcase
    return r;
  endfunction

endpackage

[hdl/wsi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wsi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/wsi_stack_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack cell
// One operand stack entry; shifts down on push and up on pop.
// ----------------------------------------------------------------------------
module wsi_stack_cell
  import wsi_pkg::*;
(
  input  logic        clk_i,
  input  cell_cmd_e   cmd_i,
  input  logic [63:0] above_i,
  input  logic [63:0] below_i,
  output logic [63:0] value_o
);

  logic [63:0] value_q, value_d;

  always_comb begin
    case (cmd_i)
      CELL_PUSH: value_d = above_i;
      CELL_POP:  value_d = below_i;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[hdl/wsi_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bytecode parser
// Walks the local header, decodes opcodes and LEB128 immediates, one byte
// per item, and hands a decoded operation to the execute stage.
// ----------------------------------------------------------------------------
module wsi_parser
  import wsi_pkg::*;
#(
  parameter int unsigned LOCAL_SLOTS = LOCAL_SLOTS_DEF,
  localparam int unsigned AW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1,
  localparam int unsigned LW = $clog2(LOCAL_SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  wsi_in_t       in_i,
  output wsi_exec_t     exec_o,
  output logic [AW-1:0] lidx_o
);

  phase_e      phase_q, phase_d, eff_phase;
  logic [63:0] acc_q, acc_d, eff_acc, acc_t, sext;
  logic [6:0]  shift_q, shift_d, eff_shift, shift_t;
  logic [31:0] groups_q, groups_d, eff_groups, groups_dec;
  logic [31:0] gcount_q, gcount_d, eff_gcount;
  logic [LW-1:0] inuse_q, inuse_d, eff_inuse, room;
  logic [7:0]  pend_q, pend_d, eff_pend;
  logic [7:0]  b;
  logic        leb_end, idx_ok, done, halt;
  status_e     status;
  exec_e       kind;
  logic [7:0]  op;
  logic [63:0] imm;

  assign b = in_i.code_byte;

  always_comb begin
    // A start byte sees a freshly cleared parser.
    if (in_i.body_start) begin
      eff_phase  = PH_DECLS;
      eff_acc    = '0;
      eff_shift  = '0;
      eff_groups = '0;
      eff_gcount = '0;
      eff_inuse  = '0;
      eff_pend   = '0;
    end else begin
      eff_phase  = phase_q;
      eff_acc    = acc_q;
      eff_shift  = shift_q;
      eff_groups = groups_q;
      eff_gcount = gcount_q;
      eff_inuse  = inuse_q;
      eff_pend   = pend_q;
    end

    acc_t   = (eff_shift < 7'd64) ? (eff_acc | ({57'd0, b[6:0]} << eff_shift[5:0])) : eff_acc;
    shift_t = (eff_shift < 7'd70) ? (eff_shift + 7'd7) : eff_shift;
    leb_end = !b[7];
    sext    = acc_t;
    if (shift_t < 7'd64 && acc_t[shift_t[5:0] - 6'd1]) begin
      sext = acc_t | (~64'd0 << shift_t[5:0]);
    end
    idx_ok     = acc_t[31:0] < 32'(eff_inuse);
    room       = LW'(LOCAL_SLOTS) - eff_inuse;
    groups_dec = eff_groups - 32'd1;

    phase_d  = eff_phase;
    acc_d    = eff_acc;
    shift_d  = eff_shift;
    groups_d = eff_groups;
    gcount_d = eff_gcount;
    inuse_d  = eff_inuse;
    pend_d   = eff_pend;
    done     = 1'b0;
    status   = ST_EXEC;
    kind     = EX_NONE;
    op       = '0;
    imm      = '0;

    case (eff_phase)
      PH_DECLS: begin
        acc_d   = acc_t;
        shift_d = shift_t;
        if (leb_end) begin
          groups_d = acc_t[31:0];
          acc_d    = '0;
          shift_d  = '0;
          phase_d  = (acc_t[31:0] != 32'd0) ? PH_GROUP_N : PH_OP;
        end
      end
      PH_GROUP_N: begin
        acc_d   = acc_t;
        shift_d = shift_t;
        if (leb_end) begin
          gcount_d = acc_t[31:0];
          acc_d    = '0;
          shift_d  = '0;
          phase_d  = PH_GROUP_T;
        end
      end
      PH_GROUP_T: begin
        inuse_d  = eff_inuse + ((eff_gcount < 32'(room)) ? eff_gcount[LW-1:0] : room);
        groups_d = groups_dec;
        phase_d  = (groups_dec != 32'd0) ? PH_GROUP_N : PH_OP;
      end
      PH_IMM_U, PH_IMM_S: begin
        acc_d   = acc_t;
        shift_d = shift_t;
        if (leb_end) begin
          done    = 1'b1;
          op      = eff_pend;
          acc_d   = '0;
          shift_d = '0;
          phase_d = PH_OP;
          case (eff_pend)
            OP_I32_CONST: begin
              kind = EX_PUSH;
              imm  = {32'd0, sext[31:0]};
            end
            OP_I64_CONST: begin
              kind = EX_PUSH;
              imm  = sext;
            end
            OP_LOCAL_GET: kind = idx_ok ? EX_PUSH_LOCAL : EX_NONE;
            OP_LOCAL_SET: kind = idx_ok ? EX_SET_LOCAL : EX_NONE;
            default:      kind = EX_NONE;
          endcase
        end
      end
      PH_OP: begin
        pend_d = b;
        if (b == OP_CALL || b == OP_LOCAL_GET || b == OP_LOCAL_SET) begin
          acc_d   = '0;
          shift_d = '0;
          phase_d = PH_IMM_U;
        end else if (b == OP_I32_CONST || b == OP_I64_CONST) begin
          acc_d   = '0;
          shift_d = '0;
          phase_d = PH_IMM_S;
        end else begin
          done = 1'b1;
          op   = b;
          case (b)
            OP_UNREACHABLE: status = ST_TRAP;
            OP_RETURN:      status = ST_RETURN;
            OP_DROP:        kind = EX_DROP;
            OP_I32_ADD, OP_I32_SUB, OP_I32_MUL, OP_I32_AND,
            OP_I32_OR, OP_I32_EQ, OP_I32_LT_S: kind = EX_BINOP;
            default:        kind = EX_NONE;
          endcase
        end
      end
      default: begin
        phase_d = eff_phase;
      end
    endcase

    // Return, trap and the last body byte all halt until the next start.
    halt = (eff_phase != PH_IDLE) && (status != ST_EXEC || in_i.body_last);
    if (halt) begin
      phase_d = PH_IDLE;
      if (status == ST_EXEC) begin
        status = ST_END;
      end
    end

    exec_o.clear  = in_i.body_start;
    exec_o.emit   = (eff_phase != PH_IDLE) && (done || in_i.body_last);
    exec_o.status = status;
    exec_o.opcode = op;
    exec_o.kind   = kind;
    exec_o.imm    = imm;
    lidx_o        = acc_t[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      shift_q  <= '0;
      groups_q <= '0;
      gcount_q <= '0;
      inuse_q  <= '0;
      pend_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      groups_q <= groups_d;
      gcount_q <= gcount_d;
      inuse_q  <= inuse_d;
      pend_q   <= pend_d;
    end
  end

endmodule

[hdl/wasm_subset_stack_interpreter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack interpreter top level
// Streams function body bytes through a parser and an execute stage that
// drives a row of shifting stack cells and a locals RAM.
// ----------------------------------------------------------------------------
// The block takes one body byte per clock cycle while the receiver takes the
// result items; the result item of a byte passes the execute register and
// then the output register: the parser decodes the byte combinationally into
// the execute register, and when that register advances the execute stage
// updates the stack cells and fills the output register. A result item that
// the receiver does not take holds the execute register, which stalls the
// input. The operand stack is a chain of cells with the top entry in the first
// cell, so push, pop and the i32 operations shift the whole chain at once.
// Locals live in a RAM read in the parser cycle; a local.set just ahead of a
// local.get to the same slot is forwarded. A start byte clears all locals at
// once through one valid bit per slot; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wasm_subset_stack_interpreter
  import wsi_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned LOCAL_SLOTS = LOCAL_SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wsi_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wsi_out_t out_data_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

  logic          accept, s2_adv;
  wsi_exec_t     pexec;
  logic [AW-1:0] p_lidx;

  logic          s2_valid_q;
  wsi_exec_t     s2_q;
  logic [AW-1:0] s2_lidx_q;

  logic [CW-1:0] count_q, count_d, base_count, new_count;
  logic [63:0]   val [STACK_DEPTH];
  cell_cmd_e     cmd, cmd0;
  logic [63:0]   cell0_in, push_val, local_val, bin_res, top_next;
  logic          wr_fire, ram_we, ram_re, hit;
  logic [63:0]   ram_rdata;

  logic          rd_fwd_q, rd_valid_q;
  logic [63:0]   fwd_data_q;
  logic          lvalid_q [LOCAL_SLOTS];

  logic          out_valid_q;
  wsi_out_t      out_q;

  assign s2_adv     = s2_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s2_valid_q || s2_adv;
  assign accept     = in_valid_i && in_ready_o;

  wsi_parser #(.LOCAL_SLOTS(LOCAL_SLOTS)) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .exec_o   (pexec),
    .lidx_o   (p_lidx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s2_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_q      <= pexec;
      s2_lidx_q <= p_lidx;
    end
  end

  // Execute stage.
  always_comb begin
    base_count = s2_q.clear ? '0 : count_q;
    local_val  = rd_valid_q ? (rd_fwd_q ? fwd_data_q : ram_rdata) : 64'd0;
    push_val   = (s2_q.kind == EX_PUSH_LOCAL) ? local_val : s2_q.imm;
    bin_res    = {val[1][63:32], wsi_binop(s2_q.opcode, val[1][31:0], val[0][31:0])};
    new_count  = base_count;
    cmd        = CELL_HOLD;
    cmd0       = CELL_HOLD;
    cell0_in   = push_val;
    wr_fire    = 1'b0;
    case (s2_q.kind)
      EX_PUSH, EX_PUSH_LOCAL: begin
        if (base_count < CW'(STACK_DEPTH)) begin
          cmd       = CELL_PUSH;
          cmd0      = CELL_PUSH;
          new_count = base_count + CW'(1);
        end
      end
      EX_DROP, EX_SET_LOCAL: begin
        if (base_count != '0) begin
          cmd       = CELL_POP;
          cmd0      = CELL_POP;
          new_count = base_count - CW'(1);
          wr_fire   = (s2_q.kind == EX_SET_LOCAL);
        end
      end
      EX_BINOP: begin
        // The result lands in the first cell while the rest move up.
        if (base_count >= CW'(2)) begin
          cmd       = CELL_POP;
          cmd0      = CELL_PUSH;
          cell0_in  = bin_res;
          new_count = base_count - CW'(1);
        end
      end
      default: begin
        new_count = base_count;
      end
    endcase
    if (!s2_adv) begin
      cmd     = CELL_HOLD;
      cmd0    = CELL_HOLD;
      wr_fire = 1'b0;
    end
    case (cmd0)
      CELL_PUSH: top_next = cell0_in;
      CELL_POP:  top_next = val[1];
      default:   top_next = val[0];
    endcase
    count_d = s2_adv ? new_count : count_q;
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [63:0] above, below;
    cell_cmd_e   ccmd;
    if (i == 0) begin : g_first
      assign above = cell0_in;
      assign ccmd  = cmd0;
    end else begin : g_rest
      assign above = val[i-1];
      assign ccmd  = cmd;
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = 64'd0;
    end else begin : g_mid
      assign below = val[i+1];
    end
    wsi_stack_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (ccmd),
      .above_i (above),
      .below_i (below),
      .value_o (val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Locals.
  assign ram_we = wr_fire;
  assign ram_re = accept && (pexec.kind == EX_PUSH_LOCAL);
  assign hit    = ram_we && (s2_lidx_q == p_lidx);

  wsi_ram #(.WIDTH(64), .DEPTH(LOCAL_SLOTS)) u_locals (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_lidx_q),
    .wdata_i (val[0]),
    .re_i    (ram_re),
    .raddr_i (p_lidx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_fwd_q   <= hit;
      fwd_data_q <= val[0];
      rd_valid_q <= lvalid_q[p_lidx] || hit;
    end
  end

  // A start byte clears every slot; it wins over a write from the old body.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOCAL_SLOTS; i++) begin
        lvalid_q[i] <= 1'b0;
      end
    end else if (accept && pexec.clear) begin
      for (int i = 0; i < LOCAL_SLOTS; i++) begin
        lvalid_q[i] <= 1'b0;
      end
    end else if (ram_we) begin
      lvalid_q[s2_lidx_q] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv && s2_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_q.emit) begin
      out_q.status    <= s2_q.status;
      out_q.opcode    <= s2_q.opcode;
      out_q.depth     <= 9'(new_count);
      out_q.top_value <= (new_count != '0) ? top_next : 64'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/wsi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpreter port checker
// Watches the top-level ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
module wsi_checker
  import wsi_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input wsi_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result item changed while stalled");

  // Input back-pressure only comes from a stalled result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled result");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (STACK_DEPTH < 512) && out_valid_i && out_data_i.depth == 9'd0
      |-> out_data_i.top_value == 64'd0)
    else $error("empty stack reports a nonzero top value");

  a_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_TRAP |-> out_data_i.opcode == OP_UNREACHABLE)
    else $error("trap status without unreachable opcode");

  a_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_RETURN |-> out_data_i.opcode == OP_RETURN)
    else $error("return status without return opcode");

endmodule

bind wasm_subset_stack_interpreter wsi_checker #(.STACK_DEPTH(STACK_DEPTH)) u_wsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack interpreter testbench
// Streams function bodies into the interpreter and checks every result item
// against an in-bench interpreter model, under varied sender and receiver
// idling, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import wsi_pkg::*;

  localparam int unsigned NSTACK = 256;
  localparam int unsigned NLOC   = 64;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  // Not part of the supported subset, so it runs as an opcode with no effect.
  localparam logic [7:0] OP_NOP = 8'h01;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  wsi_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  wsi_out_t out_data_o;

  wasm_subset_stack_interpreter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Interpreter model state.
  logic [63:0] m_stack [NSTACK];
  int unsigned m_depth;
  logic [63:0] m_locals [NLOC];
  int unsigned m_nlocals;
  phase_e      m_phase;
  logic [63:0] m_acc;
  int unsigned m_shift;
  logic [31:0] m_groups_left;
  logic [31:0] m_group_n;
  logic [7:0]  m_pending;
  logic        m_halted;

  wsi_out_t    expected_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  longint unsigned cycles = 0;

  function automatic bit leb_absorb(logic [7:0] b);
    if (m_shift < 64) m_acc |= 64'(b[6:0]) << m_shift;
    if (m_shift < 70) m_shift += 7;
    return !b[7];
  endfunction

  function automatic void model_push(logic [63:0] v);
    if (m_depth < NSTACK) begin
      m_stack[m_depth] = v;
      m_depth++;
    end
  endfunction

  function automatic status_e run_simple(logic [7:0] op);
    logic [31:0] a, b, r;
    case (op)
      OP_UNREACHABLE: return ST_TRAP;
      OP_RETURN: return ST_RETURN;
      OP_DROP: if (m_depth > 0) m_depth--;
      OP_I32_ADD, OP_I32_SUB, OP_I32_MUL, OP_I32_AND, OP_I32_OR, OP_I32_EQ,
      OP_I32_LT_S: begin
        if (m_depth >= 2) begin
          b = m_stack[m_depth-1][31:0];
          m_depth--;
          a = m_stack[m_depth-1][31:0];
          case (op)
            OP_I32_ADD: r = a + b;
            OP_I32_SUB: r = a - b;
            OP_I32_MUL: r = a * b;
            OP_I32_AND: r = a & b;
            OP_I32_OR:  r = a | b;
            OP_I32_EQ:  r = (a == b) ? 32'd1 : 32'd0;
            default:    r = ((a ^ 32'h8000_0000) < (b ^ 32'h8000_0000)) ? 32'd1 : 32'd0;
          endcase
          m_stack[m_depth-1][31:0] = r;
        end
      end
      default: ;
    endcase
    return ST_EXEC;
  endfunction

  function automatic void run_immediate(logic [7:0] op);
    logic [63:0] v;
    logic [31:0] idx;
    v = m_acc;
    idx = m_acc[31:0];
    if (op == OP_I32_CONST || op == OP_I64_CONST) begin
      if (m_shift < 64 && m_acc[m_shift-1]) v |= ~64'd0 << m_shift;
      if (op == OP_I32_CONST) v &= 64'hFFFF_FFFF;
      model_push(v);
    end else if (op == OP_LOCAL_GET) begin
      if (idx < m_nlocals) model_push(m_locals[idx]);
    end else if (op == OP_LOCAL_SET) begin
      if (m_depth > 0 && idx < m_nlocals) begin
        m_depth--;
        m_locals[idx] = m_stack[m_depth];
      end
    end
  endfunction

  function automatic void interpreter_reset();
    foreach (m_locals[i]) m_locals[i] = '0;
    m_depth = 0; m_nlocals = 0; m_phase = PH_IDLE; m_acc = '0; m_shift = 0;
    m_groups_left = '0; m_group_n = '0; m_pending = '0; m_halted = 1'b1;
  endfunction

  // Advances the model by one byte and queues the result item it causes.
  function automatic void interpret_byte(wsi_in_t it);
    bit done;
    status_e st;
    logic [7:0] op;
    int unsigned room;
    wsi_out_t r;
    done = 0; st = ST_EXEC; op = '0;
    if (it.body_start) begin
      foreach (m_locals[i]) m_locals[i] = '0;
      m_depth = 0; m_nlocals = 0; m_phase = PH_DECLS; m_acc = '0; m_shift = 0;
      m_groups_left = '0; m_group_n = '0; m_pending = '0; m_halted = 1'b0;
    end
    if (m_halted) return;
    case (m_phase)
      PH_DECLS: if (leb_absorb(it.code_byte)) begin
        m_groups_left = m_acc[31:0];
        m_acc = '0; m_shift = 0;
        m_phase = (m_groups_left != 0) ? PH_GROUP_N : PH_OP;
      end
      PH_GROUP_N: if (leb_absorb(it.code_byte)) begin
        m_group_n = m_acc[31:0];
        m_acc = '0; m_shift = 0;
        m_phase = PH_GROUP_T;
      end
      PH_GROUP_T: begin
        room = NLOC - m_nlocals;
        m_nlocals += (m_group_n < room) ? m_group_n : room;
        m_groups_left--;
        m_phase = (m_groups_left != 0) ? PH_GROUP_N : PH_OP;
      end
      PH_IMM_U, PH_IMM_S: if (leb_absorb(it.code_byte)) begin
        run_immediate(m_pending);
        op = m_pending; done = 1;
        m_acc = '0; m_shift = 0;
        m_phase = PH_OP;
      end
      default: begin
        m_pending = it.code_byte;
        if (it.code_byte inside {OP_CALL, OP_LOCAL_GET, OP_LOCAL_SET}) begin
          m_acc = '0; m_shift = 0; m_phase = PH_IMM_U;
        end else if (it.code_byte inside {OP_I32_CONST, OP_I64_CONST}) begin
          m_acc = '0; m_shift = 0; m_phase = PH_IMM_S;
        end else begin
          st = run_simple(it.code_byte);
          op = it.code_byte; done = 1;
        end
      end
    endcase
    if (st != ST_EXEC || it.body_last) begin
      m_halted = 1'b1;
      m_phase = PH_IDLE;
      if (st == ST_EXEC) st = ST_END;
    end
    if (!done && !it.body_last) return;
    r.status = st;
    r.opcode = op;
    r.depth = m_depth[8:0];
    r.top_value = (m_depth > 0) ? m_stack[m_depth-1] : 64'd0;
    expected_q.push_back(r);
  endfunction

  // Sends one item and predicts its result when it is accepted. Valid stays
  // high after acceptance; idle cycles in the next call or wait_drained take it down.
  task automatic send_byte(logic [7:0] b, bit start = 0, bit last = 0);
    wsi_in_t it;
    it.code_byte = b; it.body_start = start; it.body_last = last;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    interpret_byte(it);
    items_sent++;
  endtask

  task automatic send_uleb(longint unsigned v);
    do begin
      send_byte({(v >> 7) != 0, v[6:0]});
      v >>= 7;
    end while (v != 0);
  endtask

  task automatic send_sleb(longint v);
    bit more;
    logic [6:0] lo;
    more = 1;
    while (more) begin
      lo = v[6:0];
      v = v >>> 7;
      more = !((v == 0 && !lo[6]) || (v == -1 && lo[6]));
      send_byte({more, lo});
    end
  endtask

  task automatic send_header(int unsigned groups, int unsigned per_group);
    send_byte(8'(groups), 1'b1);
    repeat (groups) begin
      send_uleb(per_group);
      send_byte(8'h7F);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: stalls at random, and holds off completely while hold_off is set.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    wsi_out_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %p", out_data_o);
      end else begin
        e = expected_q.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: status %0d/%0d opcode %h/%h depth %0d/%0d top %h/%h",
                     e.status, out_data_o.status, e.opcode, out_data_o.opcode,
                     e.depth, out_data_o.depth, e.top_value, out_data_o.top_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed_ops();
    send_header(2, 3);
    send_byte(OP_I32_CONST); send_sleb(-1);
    send_byte(OP_I64_CONST); send_sleb(64'sh7FFF_FFFF_FFFF_FFFF);
    send_byte(OP_I64_CONST); send_sleb(64'sh8000_0000_0000_0000);
    send_byte(OP_I32_ADD); send_byte(OP_I32_SUB); send_byte(OP_I32_MUL);
    send_byte(OP_LOCAL_SET); send_uleb(5);
    send_byte(OP_LOCAL_GET); send_uleb(5);
    send_byte(OP_LOCAL_GET); send_uleb(6);   // Bad index does nothing.
    send_byte(OP_I32_CONST); send_sleb(63);
    send_byte(OP_I32_AND); send_byte(OP_I32_EQ); send_byte(OP_I32_OR);
    send_byte(OP_I32_LT_S); send_byte(OP_DROP); send_byte(OP_DROP);
    send_byte(OP_DROP); send_byte(OP_I32_ADD);   // Empty stack does nothing.
    send_byte(OP_CALL); send_uleb(300);
    send_byte(8'hFF); send_byte(OP_NOP);
    send_byte(OP_RETURN);
    send_byte(OP_NOP); // Ignored while halted.
    send_header(0, 0);
    send_byte(OP_UNREACHABLE, 1'b0, 1'b1);
    send_header(1, 100);   // More locals than slots.
    send_byte(OP_LOCAL_SET); send_byte(8'hBF); send_byte(8'h00, 1'b0, 1'b1);
    // Overlong immediate: shift saturates.
    send_header(0, 0);
    send_byte(OP_I64_CONST); repeat (11) send_byte(8'hFF); send_byte(8'h7F);
    send_byte(OP_I32_CONST, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic send_random_body(int unsigned ops);
    int unsigned k;
    send_header($urandom_range(3), $urandom_range(40));
    for (int i = 0; i < ops; i++) begin
      k = $urandom_range(99);
      if (k < 20) begin
        send_byte(OP_I32_CONST);
        send_sleb(longint'({$urandom, $urandom}) >>> $urandom_range(63));
      end
      else if (k < 30) begin send_byte(OP_I64_CONST); send_sleb(longint'({$urandom, $urandom})); end
      else if (k < 40) begin send_byte(OP_LOCAL_GET); send_uleb($urandom_range(70)); end
      else if (k < 50) begin send_byte(OP_LOCAL_SET); send_uleb($urandom_range(70)); end
      else if (k < 52) begin send_byte(OP_CALL); send_uleb($urandom); end
      else if (k < 53) send_byte(OP_DROP);
      else if (k < 54) send_byte(8'($urandom));
      else if (k < 55 && $urandom_range(3) == 0) begin send_byte(OP_RETURN); return; end
      else if (k < 56 && $urandom_range(3) == 0) begin send_byte(OP_UNREACHABLE); return; end
      else begin
        case ($urandom_range(6))
          0: send_byte(OP_I32_ADD); 1: send_byte(OP_I32_SUB); 2: send_byte(OP_I32_MUL);
          3: send_byte(OP_I32_AND); 4: send_byte(OP_I32_OR); 5: send_byte(OP_I32_EQ);
          default: send_byte(OP_I32_LT_S);
        endcase
      end
    end
    send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_random_phase(int si, int rs, int unsigned target);
    int unsigned stop;
    send_idle_pct = si; recv_stall_pct = rs;
    stop = items_sent + target;
    while (items_sent < stop) send_random_body($urandom_range(1, 20));
    wait_drained();
  endtask

  task automatic test_raw_bytes();
    repeat (60) send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(5) == 0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin repeat (200) @(posedge clk_i); hold_off = 1'b0; end
      begin
        send_header(0, 0);
        repeat (40) begin send_byte(OP_I32_CONST); send_sleb(7); end
      end
    join
    wait_drained();
  endtask

  task automatic test_deep_stack();
    send_header(0, 0);
    repeat (262) begin
      send_byte(OP_I64_CONST);
      send_sleb(longint'($urandom_range(127)) - 64);
    end
    repeat (10) send_byte(OP_I32_ADD);
    send_byte(OP_NOP, 1'b0, 1'b1);
    wait_drained();
  endtask

  initial begin
    interpreter_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_deep_stack();
    test_backpressure();
    test_raw_bytes();
    test_random_phase(0, 0, 75);
    test_random_phase(62, 0, 75);
    test_random_phase(0, 62, 75);
    test_random_phase(23, 23, 75);
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d body bytes and checked %0d result items across all opcodes,",
             items_sent, results_seen);
    $display("header shapes, halting cases and four idling mixes; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/wsi_pkg.sv
hdl/wsi_ram.sv
hdl/wsi_stack_cell.sv
hdl/wsi_parser.sv
hdl/wasm_subset_stack_interpreter.sv
hdl/wsi_checker.sv
dv/testbench.sv
